// ===== sv/imh_pkg.sv =====
// Shared constants and types for the indexed min-heap block.
package imh_pkg;

  localparam int Capacity = 1024;
  localparam int NodeSpace = 1024;
  localparam int KeyBits = 32;
  localparam int NodeBits = 10;
  localparam int PosBits = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [NodeBits-1:0] node_t;
  typedef logic [PosBits-1:0] pos_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_ABSENT = 3'd3,
    ST_NOT_LOWER = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  // One heap slot: node id and key.
  typedef struct packed {
    node_t node;
    key_t key;
  } slot_t;

  // Position-map entry.
  typedef struct packed {
    logic valid;
    pos_t pos;
  } pmap_t;

  // Slot memory port bundle.
  typedef struct packed {
    logic we;
    pos_t waddr;
    slot_t wdata;
    pos_t raddr;
  } slot_req_t;

  typedef struct packed {
    logic we;
    node_t waddr;
    pmap_t wdata;
    node_t raddr;
  } pmap_req_t;

endpackage

// ===== sv/imh_slot_ram.sv =====
// Heap slot memory: one write port, one registered read port.
module imh_slot_ram (
  input  logic              clk,
  input  imh_pkg::slot_req_t req,
  output imh_pkg::slot_t     rdata
);

  imh_pkg::slot_t mem [imh_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== sv/imh_pmap_ram.sv =====
// Position map memory with a clearing pass after reset.
module imh_pmap_ram (
  input  logic               clk,
  input  logic               rst,
  input  imh_pkg::pmap_req_t req,
  output imh_pkg::pmap_t     rdata,
  output logic               clear_busy
);

  imh_pkg::pmap_t mem [imh_pkg::NodeSpace];
  imh_pkg::node_t clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == imh_pkg::node_t'(imh_pkg::NodeSpace - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clear_addr] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== sv/imh_ctrl.sv =====
// Command sequencer: reads, compares and swaps heap slots through the memories.
module imh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_busy,
  input  logic                in_valid,
  output logic                in_ready,
  input  imh_pkg::cmd_t       in_cmd,
  input  imh_pkg::node_t      in_node,
  input  imh_pkg::key_t       in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [131:0]        out_data,
  output imh_pkg::slot_req_t  sreq,
  input  imh_pkg::slot_t      srdata,
  output imh_pkg::pmap_req_t  preq,
  input  imh_pkg::pmap_t      prdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOOK, S_DISPATCH, S_EXT_RD, S_EXT_WAIT, S_EXT_MOVE,
    S_DEC_RD, S_DEC_WAIT, S_DEC_CHK,
    S_UP_RD, S_UP_WAIT, S_UP_CMP, S_UP_MAP,
    S_DN_RDL, S_DN_RDR, S_DN_GETL, S_DN_GETR, S_DN_MAP,
    S_FIN_RD, S_FIN_WAIT, S_FIN_NODE, S_FIN_NWAIT, S_FIN_KWAIT, S_OUT
  } state_t;

  state_t state;
  imh_pkg::cmd_t cmd;
  imh_pkg::node_t node;
  imh_pkg::key_t key;
  imh_pkg::count_t count;
  imh_pkg::pmap_t pm;
  imh_pkg::pos_t pos;
  imh_pkg::slot_t cur;       // entry being sifted
  imh_pkg::slot_t other;     // smallest of cur and its children (sift-down)
  imh_pkg::pos_t other_pos;
  logic have_left;
  imh_pkg::status_t status;
  imh_pkg::node_t rem_node;
  imh_pkg::key_t rem_key;
  imh_pkg::slot_t root;
  logic present;
  imh_pkg::key_t nkey;

  logic [imh_pkg::CountBits:0] left_w, right_w;
  assign left_w = {1'b0, pos, 1'b1};
  assign right_w = left_w + (imh_pkg::CountBits + 1)'(1);

  assign in_ready = (state == S_IDLE) && !clear_busy;
  assign out_valid = (state == S_OUT);
  assign out_data = {nkey, present, count, root.key, root.node, (count != '0),
                     rem_key, rem_node, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sreq <= '0;
      preq <= '0;
    end else begin
      sreq.we <= 1'b0;
      preq.we <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= in_cmd;
            node <= in_node;
            key <= in_key;
            status <= imh_pkg::ST_OK;
            rem_node <= '0;
            rem_key <= '0;
            preq.raddr <= in_node;
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_DISPATCH;
        S_DISPATCH: begin
          pm <= prdata;
          case (cmd)
            imh_pkg::CMD_INSERT: begin
              if (prdata.valid) begin
                status <= imh_pkg::ST_DUPLICATE;
                state <= S_FIN_RD;
              end else if (count == imh_pkg::count_t'(imh_pkg::Capacity)) begin
                status <= imh_pkg::ST_FULL;
                state <= S_FIN_RD;
              end else begin
                pos <= imh_pkg::pos_t'(count);
                cur <= '{node: node, key: key};
                count <= count + 1'b1;
                state <= S_UP_RD;
              end
            end
            imh_pkg::CMD_EXTRACT: begin
              if (count == '0) begin
                status <= imh_pkg::ST_EMPTY;
                state <= S_FIN_RD;
              end else begin
                sreq.raddr <= '0;
                state <= S_EXT_RD;
              end
            end
            imh_pkg::CMD_DECREASE: begin
              if (!prdata.valid || {1'b0, prdata.pos} >= count) begin
                status <= imh_pkg::ST_ABSENT;
                state <= S_FIN_RD;
              end else begin
                sreq.raddr <= prdata.pos;
                state <= S_DEC_RD;
              end
            end
            default: state <= S_FIN_RD;
          endcase
        end
        S_EXT_RD: begin
          sreq.raddr <= imh_pkg::pos_t'(count - 1'b1);
          state <= S_EXT_WAIT;
        end
        S_EXT_WAIT: begin
          rem_node <= srdata.node;
          rem_key <= srdata.key;
          preq.we <= 1'b1;
          preq.waddr <= srdata.node;
          preq.wdata <= '0;
          count <= count - 1'b1;
          state <= S_EXT_MOVE;
        end
        S_EXT_MOVE: begin
          cur <= srdata;
          pos <= '0;
          if (count == '0) begin
            state <= S_FIN_RD;
          end else begin
            state <= S_DN_RDL;
          end
        end
        S_DEC_RD: state <= S_DEC_WAIT;
        S_DEC_WAIT: begin
          if (srdata.key < key) begin
            status <= imh_pkg::ST_NOT_LOWER;
            state <= S_FIN_RD;
          end else begin
            pos <= pm.pos;
            cur <= '{node: node, key: key};
            state <= S_UP_RD;
          end
        end
        // Sift up: compare with parent, move parent down or settle.
        S_UP_RD: begin
          if (pos == '0) begin
            sreq.we <= 1'b1;
            sreq.waddr <= pos;
            sreq.wdata <= cur;
            preq.we <= 1'b1;
            preq.waddr <= cur.node;
            preq.wdata <= '{valid: 1'b1, pos: pos};
            state <= S_FIN_RD;
          end else begin
            other_pos <= (pos - 1'b1) >> 1;
            sreq.raddr <= (pos - 1'b1) >> 1;
            state <= S_UP_WAIT;
          end
        end
        S_UP_WAIT: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (srdata.key > cur.key) begin
            sreq.we <= 1'b1;
            sreq.waddr <= pos;
            sreq.wdata <= srdata;
            preq.we <= 1'b1;
            preq.waddr <= srdata.node;
            preq.wdata <= '{valid: 1'b1, pos: pos};
            pos <= other_pos;
            state <= S_UP_RD;
          end else begin
            sreq.we <= 1'b1;
            sreq.waddr <= pos;
            sreq.wdata <= cur;
            preq.we <= 1'b1;
            preq.waddr <= cur.node;
            preq.wdata <= '{valid: 1'b1, pos: pos};
            state <= S_FIN_RD;
          end
        end
        // Sift down: read children, pick smallest, move it up or settle.
        S_DN_RDL: begin
          have_left <= left_w < (imh_pkg::CountBits + 1)'(count);
          sreq.raddr <= left_w[imh_pkg::PosBits-1:0];
          state <= S_DN_RDR;
        end
        S_DN_RDR: begin
          sreq.raddr <= right_w[imh_pkg::PosBits-1:0];
          state <= S_DN_GETL;
        end
        S_DN_GETL: begin
          other <= cur;
          other_pos <= pos;
          if (have_left && srdata.key < cur.key) begin
            other <= srdata;
            other_pos <= left_w[imh_pkg::PosBits-1:0];
          end
          state <= S_DN_GETR;
        end
        S_DN_GETR: begin
          if (right_w < (imh_pkg::CountBits + 1)'(count) && srdata.key < other.key) begin
            other <= srdata;
            other_pos <= right_w[imh_pkg::PosBits-1:0];
          end
          state <= S_DN_MAP;
        end
        S_DN_MAP: begin
          sreq.we <= 1'b1;
          sreq.waddr <= pos;
          preq.we <= 1'b1;
          if (other_pos == pos) begin
            sreq.wdata <= cur;
            preq.waddr <= cur.node;
            preq.wdata <= '{valid: 1'b1, pos: pos};
            state <= S_FIN_RD;
          end else begin
            sreq.wdata <= other;
            preq.waddr <= other.node;
            preq.wdata <= '{valid: 1'b1, pos: pos};
            pos <= other_pos;
            state <= S_DN_RDL;
          end
        end
        // Gather result: root slot, then queried node's key.
        S_FIN_RD: begin
          sreq.raddr <= '0;
          preq.raddr <= node;
          state <= S_FIN_WAIT;
        end
        S_FIN_WAIT: state <= S_FIN_NODE;
        S_FIN_NODE: begin
          root <= (count == '0) ? '0 : srdata;
          present <= prdata.valid && ({1'b0, prdata.pos} < count);
          sreq.raddr <= prdata.pos;
          state <= S_FIN_NWAIT;
        end
        S_FIN_NWAIT: state <= S_FIN_KWAIT;
        S_FIN_KWAIT: begin
          nkey <= present ? srdata.key : '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/indexed_min_heap_decrease_key_top.sv =====
// Top level of the indexed binary min-heap with decrease-key.
// One request at a time: insert, extract-min, decrease-key or query. Sift-up and
// sift-down walk the heap one level at a time, bounded by the single read port of the
// slot memory. After reset the position map is cleared, all 1024 entries, before the
// first request is taken.
module indexed_min_heap_decrease_key_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // cmd[1:0], node_id[11:2], key[43:12]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], removed_node[12:3], removed_key[44:13], min_valid[45],
  // min_node[55:46], min_key[87:56], count[98:88], node_present[99], node_key[131:100]
  output logic [135:0] m_axis_tdata
);

  imh_pkg::slot_req_t sreq;
  imh_pkg::slot_t srdata;
  imh_pkg::pmap_req_t preq;
  imh_pkg::pmap_t prdata;
  logic clear_busy;
  logic [131:0] odata;

  imh_slot_ram u_slot (.clk(clk), .req(sreq), .rdata(srdata));
  imh_pmap_ram u_pmap (.clk(clk), .rst(rst), .req(preq), .rdata(prdata),
                       .clear_busy(clear_busy));

  imh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .clear_busy(clear_busy),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(imh_pkg::cmd_t'(s_axis_tdata[1:0])),
    .in_node(s_axis_tdata[11:2]), .in_key(s_axis_tdata[43:12]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(odata),
    .sreq(sreq), .srdata(srdata), .preq(preq), .prdata(prdata)
  );

  assign m_axis_tdata = {4'b0, odata};

  logic unused_bits;
  assign unused_bits = ^s_axis_tdata[47:44];

endmodule

// ===== sv/imh_checker.sv =====
// Port-level checks for the heap block, bound to the top level.
module imh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("request taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed");

  a_min_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[45] == (m_axis_tdata[98:88] != 11'd0)))
    else $error("min_valid disagrees with count");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5) else $error("bad status");

endmodule

bind indexed_min_heap_decrease_key_top imh_checker u_chk (.*);
